@@ hdl/rtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the voxel terrain column renderer
// Item layouts, request kinds, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int MAP_SHIFT_DEF     = 10;
    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 256;

    // Iterative divider operand widths
    localparam int DIV_W = 48;
    localparam int DEN_W = 32;

    // Q12.20 depth constants
    localparam logic [31:0] NEAR_Z      = 32'd1048576;
    localparam logic [31:0] START_STEP  = 32'd104858;
    localparam logic [31:0] STEP_GROWTH = 32'd262;
    localparam logic [47:0] STRETCH_NUM = 48'd350 << 36;

    // Register reset values
    localparam logic [31:0]        CAM_X_RST      = 32'd0;
    localparam logic [31:0]        CAM_Z_RST      = 32'd0;
    localparam logic signed [15:0] CAM_HEIGHT_RST = 16'sd100;
    localparam logic signed [9:0]  HORIZON_RST    = 10'sd0;
    localparam logic signed [15:0] SIN_YAW_RST    = 16'sd0;
    localparam logic signed [15:0] COS_YAW_RST    = 16'sd16384;
    localparam logic [15:0]        FOV_RST        = 16'd4096;
    localparam logic [31:0]        FAR_LIMIT_RST  = 32'd1048576000;

    typedef enum logic [1:0] {
        KIND_MAP_WRITE = 2'd0,
        KIND_START     = 2'd1,
        KIND_RENDER    = 2'd2,
        KIND_UNUSED    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_CAM_X      = 3'd0,
        CFG_CAM_Z      = 3'd1,
        CFG_CAM_HEIGHT = 3'd2,
        CFG_HORIZON    = 3'd3,
        CFG_SIN_YAW    = 3'd4,
        CFG_COS_YAW    = 3'd5,
        CFG_FOV        = 3'd6,
        CFG_FAR_LIMIT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] map_address;
        logic [7:0]  altitude;
        logic [31:0] cell_color;
    } t_in_item;

    typedef struct packed {
        logic        span_valid;
        logic [7:0]  column;
        logic [8:0]  top;
        logic [8:0]  bottom;
        logic [31:0] span_color;
        logic        frame_done;
    } t_out_item;

endpackage
`default_nettype wire

@@ hdl/rtc_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_stream_if: valid/ready channel
// Carries one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface rtc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/rtc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hdl/rtc_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_div: unsigned restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module rtc_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [rtc_pkg::DIV_W-1:0] i_dividend,
    input  wire [rtc_pkg::DEN_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [rtc_pkg::DIV_W-1:0] o_quotient
);
    import rtc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[DEN_W-1:0], o_quotient[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_cnt      <= CNT_W'(DIV_W);
                r_rem      <= '0;
                r_den      <= i_divisor;
                o_quotient <= i_dividend;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract where it fits
                r_rem      <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
                o_quotient <= {o_quotient[DIV_W-2:0], fits};
                r_cnt      <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hdl/voxel_terrain_column_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_terrain_column_renderer: heightmap terrain renderer, front to back
// Map loads, frame start, one column per render request; emits spans and frame-done items.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  i_in     in   valid/ready         kind, map_address, altitude, cell_color
//  o_out    out  valid/ready         span_valid, column, top, bottom,
//                                    span_color, frame_done
//  i_cfg_*  in   write enable only   index 0..7, data 32 bit
//
//  Map write and ignored requests leave the block in idle. A render request
//  inside a row runs the map/occlusion read, height multiply and occlusion update.
//  The first column of a row runs two passes of the bit-serial divider (depth/fov,
//  350/depth) and eight setup and render steps.
//  A frame start runs a clearing pass over every entry of the occlusion
//  memory. Reset is synchronous; the map memories are not cleared.
//  A full output register stalls the occlusion update step and the frame end.
// ----------------------------------------------------------------------------
module voxel_terrain_column_renderer #(
    parameter int MAP_SHIFT     = rtc_pkg::MAP_SHIFT_DEF,
    parameter int SCREEN_WIDTH  = rtc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rtc_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rtc_stream_if.sink   i_in,
    rtc_stream_if.source o_out,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_index,
    input  wire [31:0]  i_cfg_data
);
    import rtc_pkg::*;

    localparam int MAP_AW = 2 * MAP_SHIFT;
    localparam int CW     = $clog2(SCREEN_WIDTH);
    localparam int OW     = $clog2(SCREEN_HEIGHT + 1);
    // screen width is a power of two: the ray step divide is a shift
    localparam int SW_SHIFT = $clog2(SCREEN_WIDTH);
    localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_WIDTH - 1);
    localparam logic [OW-1:0] SCR_H    = OW'(SCREEN_HEIGHT);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_ZF, S_INV, S_MA, S_MB, S_MC, S_MD,
        S_LEFT, S_RD, S_MUL, S_WR, S_FDONE
    } t_state;

    // configuration
    logic [31:0]        r_cam_x, r_cam_z, r_far;
    logic signed [15:0] r_cam_h, r_sin, r_cos;
    logic signed [9:0]  r_hor;
    logic [15:0]        r_fov;

    // control and row state
    t_state             r_state;
    logic               r_active;
    logic [CW-1:0]      r_col, r_clr;
    logic [31:0]        r_depth, r_step;
    logic [31:0]        r_ray_x, r_ray_y, r_ray_dx, r_ray_dy, r_inv;
    logic [43:0]        r_zf;
    logic signed [48:0] r_m0, r_m1;
    logic signed [60:0] r_m2, r_m3;
    logic signed [49:0] r_prod;
    logic               r_div_start;
    logic [DIV_W-1:0]   r_div_num;
    logic [DEN_W-1:0]   r_div_den;
    logic               r_out_valid;
    t_out_item          r_out;

    // memory ports
    logic [7:0]          alt_q;
    logic [31:0]         color_q;
    logic [OW-1:0]       occ_q;
    logic                map_we, rd_en, occ_we;
    logic [MAP_AW-1:0]   map_waddr, map_raddr;
    logic [CW-1:0]       occ_waddr;
    logic [OW-1:0]       occ_wdata;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    // datapath
    logic [15:0]         f_eff;
    logic [31:0]         z_eff;
    logic                in_xfer, out_free;
    logic signed [62:0]  lx, ly;
    logic signed [31:0]  tdx;
    logic signed [49:0]  nm1;
    logic signed [32:0]  tdy;
    logic [32:0]         mag_dx, mag_dy;
    logic [32:0]         qx_mag, qy_mag;
    logic [31:0]         step_x, step_y;
    logic signed [16:0]  dh;
    logic signed [51:0]  h;
    logic [OW-1:0]       row;
    logic                emit;
    logic [47:0]         grow;
    logic [36:0]         depth_sum;
    logic [32:0]         step_sum;

    assign f_eff    = (r_fov == '0) ? 16'd1 : r_fov;
    assign z_eff    = (r_depth == '0) ? 32'd1 : r_depth;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign map_we    = in_xfer && (i_in.data.kind == KIND_MAP_WRITE);
    assign map_waddr = MAP_AW'(i_in.data.map_address);
    assign map_raddr = {r_ray_y[16 +: MAP_SHIFT], r_ray_x[16 +: MAP_SHIFT]};
    // look ahead while idle so a render request finds its data next cycle
    assign rd_en     = (r_state == S_IDLE) || (r_state == S_RD);

    assign lx     = -63'(r_m0) - 63'(r_m2);
    assign ly     = 63'(r_m1) - 63'(r_m3);
    assign tdx    = 32'(r_m0 >>> 17);
    assign nm1    = -50'(r_m1);
    assign tdy    = 33'(nm1 >>> 17);
    assign mag_dx = tdx[31] ? 33'(-34'(tdx)) : 33'(tdx);
    assign mag_dy = tdy[32] ? 33'(-34'(tdy)) : 33'(tdy);
    // divide the magnitude, then restore the sign (truncates toward zero)
    assign qx_mag = mag_dx >> SW_SHIFT;
    assign qy_mag = mag_dy >> SW_SHIFT;
    assign step_x = tdx[31] ? 32'(-qx_mag) : qx_mag[31:0];
    assign step_y = tdy[32] ? 32'(-qy_mag) : qy_mag[31:0];

    assign dh = 17'(r_cam_h) - $signed({9'd0, alt_q});
    assign h  = 52'(r_prod) + (52'(r_hor) <<< 16);

    always_comb begin
        if (h[51]) begin
            row = '0;
        end else if (h[51:16] > 36'(SCREEN_HEIGHT)) begin
            row = SCR_H;
        end else begin
            row = OW'(h[51:16]);
        end
    end

    assign emit      = row < occ_q;
    assign grow      = r_step * f_eff;
    assign depth_sum = {5'd0, r_depth} + {1'b0, grow[47:12]};
    assign step_sum  = {1'b0, r_step} + {1'b0, STEP_GROWTH};

    assign occ_we    = (r_state == S_CLEAR) || ((r_state == S_WR) && emit && out_free);
    assign occ_waddr = (r_state == S_CLEAR) ? r_clr : r_col;
    assign occ_wdata = (r_state == S_CLEAR) ? SCR_H : row;

    rtc_ram #(.WIDTH(8), .DEPTH(1 << MAP_AW)) u_height (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr),
        .i_wdata(i_in.data.altitude), .i_re(rd_en), .i_raddr(map_raddr),
        .o_rdata(alt_q)
    );

    rtc_ram #(.WIDTH(32), .DEPTH(1 << MAP_AW)) u_color (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr),
        .i_wdata(i_in.data.cell_color), .i_re(rd_en), .i_raddr(map_raddr),
        .o_rdata(color_q)
    );

    rtc_ram #(.WIDTH(OW), .DEPTH(SCREEN_WIDTH)) u_occ (
        .i_clk(i_clk), .i_we(occ_we), .i_waddr(occ_waddr),
        .i_wdata(occ_wdata), .i_re(rd_en), .i_raddr(r_col),
        .o_rdata(occ_q)
    );

    rtc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dividend(r_div_num), .i_divisor(r_div_den),
        .o_done(div_done), .o_quotient(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= CAM_X_RST;
            r_cam_z     <= CAM_Z_RST;
            r_cam_h     <= CAM_HEIGHT_RST;
            r_hor       <= HORIZON_RST;
            r_sin       <= SIN_YAW_RST;
            r_cos       <= COS_YAW_RST;
            r_fov       <= FOV_RST;
            r_far       <= FAR_LIMIT_RST;
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_col       <= '0;
            r_clr       <= '0;
            r_depth     <= NEAR_Z;
            r_step      <= START_STEP;
            r_ray_x     <= '0;
            r_ray_y     <= '0;
            r_ray_dx    <= '0;
            r_ray_dy    <= '0;
            r_inv       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAM_X:      r_cam_x <= i_cfg_data;
                    CFG_CAM_Z:      r_cam_z <= i_cfg_data;
                    CFG_CAM_HEIGHT: r_cam_h <= i_cfg_data[15:0];
                    CFG_HORIZON:    r_hor   <= i_cfg_data[9:0];
                    CFG_SIN_YAW:    r_sin   <= i_cfg_data[15:0];
                    CFG_COS_YAW:    r_cos   <= i_cfg_data[15:0];
                    CFG_FOV:        r_fov   <= i_cfg_data[15:0];
                    CFG_FAR_LIMIT:  r_far   <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_in.data.kind == KIND_START)) begin
                        r_depth  <= NEAR_Z;
                        r_step   <= START_STEP;
                        r_col    <= '0;
                        r_clr    <= '0;
                        r_active <= 1'b1;
                        r_state  <= S_CLEAR;
                    end else if (in_xfer && (i_in.data.kind == KIND_RENDER) && r_active) begin
                        if (r_col != '0) begin
                            r_state <= S_MUL;
                        end else if (r_depth >= r_far) begin
                            r_active <= 1'b0;
                            r_state  <= S_FDONE;
                        end else begin
                            r_div_num   <= DIV_W'({z_eff, 12'd0});
                            r_div_den   <= DEN_W'(f_eff);
                            r_div_start <= 1'b1;
                            r_state     <= S_ZF;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_COL) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ZF: begin
                    if (div_done) begin
                        r_zf        <= div_q[43:0];
                        r_div_num   <= STRETCH_NUM;
                        r_div_den   <= z_eff;
                        r_div_start <= 1'b1;
                        r_state     <= S_INV;
                    end
                end
                S_INV: begin
                    if (div_done) begin
                        r_inv   <= div_q[31:0];
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    r_m0    <= r_cos * $signed({1'b0, z_eff});
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_m1    <= r_sin * $signed({1'b0, z_eff});
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_m2    <= r_sin * $signed({1'b0, r_zf});
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_m3    <= r_cos * $signed({1'b0, r_zf});
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    r_ray_x  <= r_cam_x + 32'(lx >>> 18);
                    r_ray_y  <= r_cam_z + 32'(ly >>> 18);
                    r_ray_dx <= step_x;
                    r_ray_dy <= step_y;
                    r_state  <= S_RD;
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= dh * $signed({1'b0, r_inv});
                    r_state <= S_WR;
                end
                S_WR: begin
                    // hold here while the output register is full
                    if (out_free) begin
                        if (emit) begin
                            r_out_valid      <= 1'b1;
                            r_out.span_valid <= 1'b1;
                            r_out.column     <= 8'(r_col);
                            r_out.top        <= 9'(row);
                            r_out.bottom     <= 9'(occ_q);
                            r_out.span_color <= color_q;
                            r_out.frame_done <= 1'b0;
                        end
                        r_ray_x <= r_ray_x + r_ray_dx;
                        r_ray_y <= r_ray_y + r_ray_dy;
                        if (r_col == LAST_COL) begin
                            r_col   <= '0;
                            r_depth <= (depth_sum[36:32] != '0) ? 32'hFFFF_FFFF
                                                                : depth_sum[31:0];
                            r_step  <= step_sum[32] ? 32'hFFFF_FFFF : step_sum[31:0];
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FDONE: begin
                    if (out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out.span_valid <= 1'b0;
                        r_out.column     <= '0;
                        r_out.top        <= '0;
                        r_out.bottom     <= '0;
                        r_out.span_color <= '0;
                        r_out.frame_done <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
